// ===== src/mecanum_platform_dynamics_step_macros.svh =====
// Assertion macros for the mecanum dynamics block.
`ifndef MECANUM_PLATFORM_DYNAMICS_STEP_MACROS_SVH
`define MECANUM_PLATFORM_DYNAMICS_STEP_MACROS_SVH
`define CHK_IMPL(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define CHK_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

// ===== src/mpd_pkg.sv =====
// Package for the mecanum dynamics block: constants, types and tables.
`default_nettype none
package mpd_pkg;
  localparam int STATE_WIDTH_DEF  = 32;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int GAIN_W = 24;
  localparam logic [31:0] GAIN_RESET = 32'd65536;
  localparam logic [31:0] CORDIC_K = 32'd652032874;
  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [33:0] PI_Q30 = 34'sd3373259426;
  localparam logic [0:0] REG_ACCEL_GAIN = 1'b0;
  localparam logic [0:0] REG_YAW_GAIN = 1'b1;

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_VEL  = 8'b00000010,
    S_CORD = 8'b00000100,
    S_MIX  = 8'b00001000,
    S_ACC  = 8'b00010000,
    S_SUM  = 8'b00100000,
    S_OUT  = 8'b01000000,
    S_MUL  = 8'b10000000
  } state_t;

  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    case (i)
      5'd0: atan_q30 = 30'h3243F6A8 & 30'h3FFFFFFF;
      5'd1: atan_q30 = 30'h1DAC6705;
      5'd2: atan_q30 = 30'h0FADBAFC;
      5'd3: atan_q30 = 30'h07F56EA6;
      5'd4: atan_q30 = 30'h03FEAB76;
      5'd5: atan_q30 = 30'h01FFD55B;
      5'd6: atan_q30 = 30'h00FFFAAA;
      5'd7: atan_q30 = 30'h007FFF55;
      5'd8: atan_q30 = 30'h003FFFEA;
      5'd9: atan_q30 = 30'h001FFFFD;
      5'd10: atan_q30 = 30'h000FFFFF;
      5'd11: atan_q30 = 30'h0007FFFF;
      5'd12: atan_q30 = 30'h0003FFFF;
      5'd13: atan_q30 = 30'h0001FFFF;
      5'd14: atan_q30 = 30'h0000FFFF;
      5'd15: atan_q30 = 30'h00007FFF;
      5'd16: atan_q30 = 30'h00003FFF;
      5'd17: atan_q30 = 30'h00001FFF;
      5'd18: atan_q30 = 30'h00000FFF;
      5'd19: atan_q30 = 30'h000007FF;
      5'd20: atan_q30 = 30'h000003FF;
      5'd21: atan_q30 = 30'h000001FF;
      5'd22: atan_q30 = 30'h000000FF;
      5'd23: atan_q30 = 30'h0000007F;
      default: atan_q30 = 30'h0;
    endcase
  endfunction
endpackage
`default_nettype wire

// ===== src/mpd_serial_mul.sv =====
// Bit-serial signed multiplier: one multiplier bit per cycle, shift-add.
`default_nettype none
module mpd_serial_mul import mpd_pkg::*; #(
  parameter int AW = 64,
  parameter int BW = 24
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic signed [AW-1:0] a,
  input  wire logic        [BW-1:0] b,
  input  wire logic                 b_signed,
  output logic                      done,
  output logic signed [AW+BW-1:0]   prod
);
  localparam int CW = $clog2(BW + 1);
  logic signed [AW+BW-1:0] acc;
  logic signed [AW+BW-1:0] mcand;
  logic [BW-1:0] mplier;
  logic [CW-1:0] cnt;
  logic busy;
  logic last;
  assign last = (cnt == CW'(BW - 1));
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
        acc <= '0;
        mcand <= (AW+BW)'(a);
        mplier <= b;
      end else if (busy) begin
        if (mplier[0]) begin
          if (last && b_signed) acc <= acc - mcand;
          else acc <= acc + mcand;
        end
        mcand <= mcand <<< 1;
        mplier <= mplier >> 1;
        cnt <= cnt + 1'b1;
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  always_comb begin
    prod = acc;
  end
endmodule
`default_nettype wire

// ===== src/mecanum_platform_dynamics_step.sv =====
// Top level of the mecanum platform dynamics step.
// One input transaction (step_ms, heading, four wheel torques) advances the
// platform state by one Euler tick and yields one result transaction with the
// full state: three velocities, three accelerations and four running sums.
// The user writes gains accel_gain (reg 0) and yaw_gain (reg 1) over the APB port
// only while idle; the block does not enforce this. Reads return the current values.
// One item is handled at a time. A shared bit-serial multiplier carries the
// fourteen products of a step; each of the seven products by step_ms is
// followed by a restoring divide by 1000 of STATE_WIDTH+10 quotient bits, and
// the CORDIC_STEPS rotations sit between the velocity and mix phases. The
// next item is taken the cycle after the result is loaded.
// Reset zeroes all state and sets both gains to 65536 (1.0 in Q8.16).
// When the receiver stalls, the result is held in the output registers with
// valid high; the next item is still accepted and computed, then waits, and
// in_ready stays low until the held result is taken.
`default_nettype none
`include "mecanum_platform_dynamics_step_macros.svh"
module mecanum_platform_dynamics_step import mpd_pkg::*; #(
  parameter int STATE_WIDTH  = STATE_WIDTH_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic        [9:0]  step_ms,
  input  wire logic signed [15:0] heading,
  input  wire logic signed [15:0] torque_front_left,
  input  wire logic signed [15:0] torque_front_right,
  input  wire logic signed [15:0] torque_rear_left,
  input  wire logic signed [15:0] torque_rear_right,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      vel_x,
  output logic signed [31:0]      vel_y,
  output logic signed [31:0]      yaw_rate,
  output logic signed [31:0]      acc_x,
  output logic signed [31:0]      acc_y,
  output logic signed [31:0]      yaw_accel,
  output logic signed [31:0]      pos_x,
  output logic signed [31:0]      pos_y,
  output logic signed [31:0]      heading_sum,
  output logic signed [31:0]      yaw_accel_sum
);
  localparam int SW = STATE_WIDTH;
  localparam int MA = 64;
  localparam int NS = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
  localparam int DW = SW + 10;
  localparam int DCW = $clog2(DW);
  localparam logic [10:0] STEP_DIV = 11'd1000;
  localparam logic [MA-1:0] STEP_HALF = 64'd500;
  localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};

  logic [GAIN_W-1:0] accel_gain, yaw_gain;
  logic signed [SW-1:0] rt [6];
  logic signed [SW-1:0] os [4];
  state_t st;
  logic [3:0] op;
  logic [4:0] ci;
  logic [9:0] ms;
  logic signed [15:0] t0, t1, t2, t3;
  logic signed [33:0] cx, cy, cz;
  logic neg;
  logic signed [19:0] c, s;
  logic signed [MA-1:0] ma_a;
  logic [GAIN_W-1:0] mb;
  logic mbs, mstart, mdone;
  logic signed [MA+GAIN_W-1:0] mprod;
  logic signed [MA-1:0] mx_acc;

  mpd_serial_mul #(.AW(MA), .BW(GAIN_W)) u_mul (
    .clk(clk), .rst(rst), .start(mstart), .a(ma_a), .b(mb), .b_signed(mbs),
    .done(mdone), .prod(mprod)
  );

  function automatic logic signed [SW-1:0] sat(input logic signed [MA-1:0] v);
    if (v > MA'(SMAX)) sat = SMAX;
    else if (v < MA'(SMIN)) sat = SMIN;
    else sat = SW'(v);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] v);
    logic signed [MA-1:0] w;
    w = MA'(v);
    if (w > 64'sd2147483647) sat32 = 32'h7FFFFFFF;
    else if (w < -64'sd2147483648) sat32 = 32'h80000000;
    else sat32 = w[31:0];
  endfunction

  // round(p/1000) ties away: restoring divide of |p|+500, one quotient bit per cycle
  logic [MA-1:0] pmag;
  logic [DW-1:0] dq, dq_next, dload;
  logic [9:0] drem, drem_next;
  logic [10:0] dtrial;
  logic [DCW-1:0] dcnt;
  logic dbusy, dneg, dbit, ddone;
  logic signed [MA-1:0] tdt;
  always_comb begin
    pmag = mprod[MA-1] ? MA'(-mprod) : MA'(mprod);
    dload = DW'(pmag + STEP_HALF);
    dtrial = {drem, dq[DW-1]};
    dbit = (dtrial >= STEP_DIV);
    drem_next = dbit ? 10'(dtrial - STEP_DIV) : dtrial[9:0];
    dq_next = {dq[DW-2:0], dbit};
    ddone = dbusy && (dcnt == DCW'(DW - 1));
    tdt = dneg ? -$signed(MA'(dq_next)) : $signed(MA'(dq_next));
  end

  logic signed [MA-1:0] r24, r8;
  always_comb begin
    r24 = MA'((mprod + 88'sd8388608) >>> 24);
    r8 = MA'((mprod + 88'sd128) >>> 8);
  end

  assign pready = 1'b1;
  always_comb begin
    unique case (paddr[2])
      REG_ACCEL_GAIN: prdata = 32'(accel_gain);
      REG_YAW_GAIN:   prdata = 32'(yaw_gain);
      default:        prdata = '0;
    endcase
  end

  assign in_ready = (st == S_IDLE);

  logic signed [33:0] dxs, dys;
  logic signed [19:0] cr, sr;
  always_comb begin
    dxs = cx >>> ci;
    dys = cy >>> ci;
    cr = 20'((cx + 34'sd8192) >>> 14);
    sr = 20'((cy + 34'sd8192) >>> 14);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      out_valid <= 1'b0;
      mstart <= 1'b0;
      dbusy <= 1'b0;
      accel_gain <= GAIN_W'(GAIN_RESET);
      yaw_gain <= GAIN_W'(GAIN_RESET);
      for (int i = 0; i < 6; i++) rt[i] <= '0;
      for (int i = 0; i < 4; i++) os[i] <= '0;
    end else begin
      mstart <= 1'b0;
      if (psel && penable && pwrite && paddr[1:0] == 2'b00 && paddr[2] == REG_ACCEL_GAIN)
        accel_gain <= pwdata[GAIN_W-1:0];
      if (psel && penable && pwrite && paddr[1:0] == 2'b00 && paddr[2] == REG_YAW_GAIN)
        yaw_gain <= pwdata[GAIN_W-1:0];
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (mdone && (st == S_VEL || st == S_SUM)) begin
        dq <= dload; drem <= '0; dcnt <= '0; dneg <= mprod[MA-1];
        dbusy <= 1'b1;
      end else if (dbusy) begin
        dq <= dq_next; drem <= drem_next; dcnt <= dcnt + 1'b1;
        if (ddone) dbusy <= 1'b0;
      end
      unique case (st)
        S_IDLE: begin
          if (in_valid) begin
            ms <= step_ms;
            t0 <= torque_front_left; t1 <= torque_front_right;
            t2 <= torque_rear_left;  t3 <= torque_rear_right;
            cz <= $signed({{2{heading[15]}}, heading, 16'b0}) <<< 1;
            op <= '0;
            ma_a <= MA'(rt[3]); mb <= GAIN_W'(step_ms); mbs <= 1'b0;
            mstart <= 1'b1;
            st <= S_VEL;
          end
        end
        S_VEL: begin
          if (ddone) begin
            rt[op[2:0]] <= sat(MA'(rt[op[2:0]]) + tdt);
            if (op == 4'd2) begin
              cx <= 34'(CORDIC_K); cy <= '0; ci <= '0;
              neg <= (cz > HALF_PI_Q30) || (cz < -HALF_PI_Q30);
              if (cz > HALF_PI_Q30) cz <= cz - PI_Q30;
              else if (cz < -HALF_PI_Q30) cz <= cz + PI_Q30;
              st <= S_CORD;
            end else begin
              op <= op + 1'b1;
              ma_a <= MA'(rt[op[2:0] + 3'd4]); mstart <= 1'b1;
            end
          end
        end
        S_CORD: begin
          if (!cz[33]) begin
            cx <= cx - dys; cy <= cy + dxs; cz <= cz - 34'(atan_q30(ci));
          end else begin
            cx <= cx + dys; cy <= cy - dxs; cz <= cz + 34'(atan_q30(ci));
          end
          ci <= ci + 1'b1;
          if (ci == 5'(NS - 1)) st <= S_MIX;
        end
        S_MIX: begin
          c <= neg ? -cr : cr;
          s <= neg ? -sr : sr;
          op <= '0;
          mx_acc <= '0;
          st <= S_MUL;
        end
        S_MUL: begin
          // products of the torque mix: ops 0..3 load coefficient pairs
          unique case (op[1:0])
            2'd0: begin ma_a <= MA'(c - s); mb <= GAIN_W'(17'(t0) + 17'(t2)); end
            2'd1: begin ma_a <= MA'(c + s); mb <= GAIN_W'(17'(t1) + 17'(t3)); end
            2'd2: begin ma_a <= MA'(c + s); mb <= GAIN_W'(17'(t0) + 17'(t2)); end
            default: begin ma_a <= MA'(s - c); mb <= GAIN_W'(17'(t1) + 17'(t3)); end
          endcase
          mbs <= 1'b1; mstart <= 1'b1;
          st <= S_ACC;
        end
        S_ACC: begin
          if (mdone) begin
            mbs <= 1'b0;
            if (op[3]) begin
              // gain products
              unique case (op[1:0])
                2'd0: begin
                  rt[3] <= sat(r24);
                  op <= 4'd2; st <= S_MUL;
                end
                2'd1: begin
                  rt[4] <= sat(r24);
                  ma_a <= MA'(18'(t0) - 18'(t1) - 18'(t2) + 18'(t3));
                  mb <= yaw_gain; mstart <= 1'b1; op <= 4'd10;
                end
                default: begin
                  rt[5] <= sat(r8);
                  op <= '0; ma_a <= MA'(rt[0]); mb <= GAIN_W'(ms); mstart <= 1'b1;
                  st <= S_SUM;
                end
              endcase
            end else if (op[0] == 1'b0) begin
              mx_acc <= MA'(mprod);
              op <= op + 1'b1; st <= S_MUL;
            end else begin
              if (op[1] == 1'b0) begin
                ma_a <= mx_acc + MA'(mprod); mb <= accel_gain; mstart <= 1'b1;
                op <= 4'd8;
                mx_acc <= '0;
              end else begin
                mx_acc <= mx_acc + MA'(mprod);
                // first gain product (x) already stored; move y mix up
                ma_a <= mx_acc + MA'(mprod); mb <= accel_gain; mstart <= 1'b1;
                op <= 4'd9;
              end
            end
          end
        end
        S_SUM: begin
          if (ddone) begin
            os[op[1:0]] <= sat(MA'(os[op[1:0]]) + tdt);
            if (op == 4'd3) st <= S_OUT;
            else begin
              op <= op + 1'b1;
              ma_a <= (op == 4'd2) ? MA'(rt[5]) : MA'(rt[op[2:0] + 3'd1]);
              mstart <= 1'b1;
            end
          end
        end
        S_OUT: begin
          if (!out_valid) begin
            vel_x <= sat32(rt[0]); vel_y <= sat32(rt[1]); yaw_rate <= sat32(rt[2]);
            acc_x <= sat32(rt[3]); acc_y <= sat32(rt[4]); yaw_accel <= sat32(rt[5]);
            pos_x <= sat32(os[0]); pos_y <= sat32(os[1]);
            heading_sum <= sat32(os[2]); yaw_accel_sum <= sat32(os[3]);
            out_valid <= 1'b1;
            st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  `CHK_IMPL(a_ready_idle, clk, rst, in_ready, st == S_IDLE, "ready outside idle")
  `CHK_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(vel_x),
            "result dropped")
  `CHK_IMPL(a_onehot, clk, rst, 1'b1, $onehot(st), "state not one-hot")
endmodule
`default_nettype wire

// ===== tb/tb_mecanum_platform_dynamics_step.sv =====
// Testbench for the mecanum platform dynamics step: random and directed ticks checked against a predictor.
`timescale 1ns / 100ps
module tb_mecanum_platform_dynamics_step;
  import mpd_pkg::*;

  typedef struct {
    logic [9:0] step_ms;
    logic signed [15:0] heading;
    logic signed [15:0] trq[4];
  } tick_t;

  typedef struct {
    logic signed [31:0] f[10];
  } plant_state_t;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0, in_ready;
  logic [9:0] step_ms = '0;
  logic signed [15:0] heading = '0;
  logic signed [15:0] torque_front_left = '0, torque_front_right = '0;
  logic signed [15:0] torque_rear_left = '0, torque_rear_right = '0;
  logic out_valid, out_ready = 1'b0;
  logic signed [31:0] vel_x, vel_y, yaw_rate, acc_x, acc_y, yaw_accel;
  logic signed [31:0] pos_x, pos_y, heading_sum, yaw_accel_sum;

  mecanum_platform_dynamics_step dut (.*);

  always #4 clk = ~clk;

  tick_t pending_ticks[$];
  plant_state_t expected_states[$];
  tick_t cur_tick;
  int tx_idle_pct = 0, rx_idle_pct = 0;
  int errors = 0;
  int results_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  // plant model
  longint model_rates[6];
  longint model_sums[4];
  longint model_accel_gain = 65536, model_yaw_gain = 65536;

  const longint ATAN_TAB[16] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
    64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
    64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF};

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint scale_by_step(longint v, int ms);
    longint p, mag;
    p = v * ms;
    mag = ((p < 0 ? -p : p) + 500) / 1000;
    return p < 0 ? -mag : mag;
  endfunction

  function automatic plant_state_t advance_plant(tick_t t);
    plant_state_t r;
    longint z, x, y, dx, dy, c, s, even, odd, mx, my, ma;
    bit neg;
    int ms;
    ms = int'(t.step_ms);
    for (int i = 0; i < 3; i++)
      model_rates[i] = clamp32(model_rates[i] + scale_by_step(model_rates[i+3], ms));
    z = longint'(t.heading) * 131072;
    x = 652032874;
    y = 0;
    neg = 0;
    if (z > 64'sd1686629713) begin
      z -= 64'sd3373259426;
      neg = 1;
    end else if (z < -64'sd1686629713) begin
      z += 64'sd3373259426;
      neg = 1;
    end
    for (int i = 0; i < 16; i++) begin
      dx = x >>> i;
      dy = y >>> i;
      if (z >= 0) begin
        x -= dy; y += dx; z -= ATAN_TAB[i];
      end else begin
        x += dy; y -= dx; z += ATAN_TAB[i];
      end
    end
    c = (x + 8192) >>> 14;
    s = (y + 8192) >>> 14;
    if (neg) begin
      c = -c;
      s = -s;
    end
    even = longint'(t.trq[0]) + longint'(t.trq[2]);
    odd = longint'(t.trq[1]) + longint'(t.trq[3]);
    mx = (c - s) * even + (c + s) * odd;
    my = (c + s) * even + (s - c) * odd;
    ma = longint'(t.trq[0]) - t.trq[1] - t.trq[2] + t.trq[3];
    model_rates[3] = clamp32((mx * model_accel_gain + 8388608) >>> 24);
    model_rates[4] = clamp32((my * model_accel_gain + 8388608) >>> 24);
    model_rates[5] = clamp32((ma * model_yaw_gain + 128) >>> 8);
    for (int i = 0; i < 3; i++)
      model_sums[i] = clamp32(model_sums[i] + scale_by_step(model_rates[i], ms));
    model_sums[3] = clamp32(model_sums[3] + scale_by_step(model_rates[5], ms));
    for (int i = 0; i < 6; i++) r.f[i] = model_rates[i][31:0];
    for (int i = 0; i < 4; i++) r.f[6+i] = model_sums[i][31:0];
    return r;
  endfunction

  // sender
  always @(posedge clk) begin
    tick_t nx;
    if (in_valid && in_ready) expected_states.push_back(advance_plant(cur_tick));
    if (!in_valid || in_ready) begin
      if (!rst && pending_ticks.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        nx = pending_ticks.pop_front();
        cur_tick <= nx;
        step_ms <= nx.step_ms;
        heading <= nx.heading;
        torque_front_left <= nx.trq[0];
        torque_front_right <= nx.trq[1];
        torque_rear_left <= nx.trq[2];
        torque_rear_right <= nx.trq[3];
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    plant_state_t exp_st;
    logic signed [31:0] got[10];
    string names[10];
    names = '{"vel_x", "vel_y", "yaw_rate", "acc_x", "acc_y", "yaw_accel",
              "pos_x", "pos_y", "heading_sum", "yaw_accel_sum"};
    got = '{vel_x, vel_y, yaw_rate, acc_x, acc_y, yaw_accel,
            pos_x, pos_y, heading_sum, yaw_accel_sum};
    if (out_valid && out_ready) begin
      results_seen++;
      if (results_seen == 300) hold_left = 1500;
      if (expected_states.size() == 0) begin
        errors++;
        $display("%0t: unexpected result transaction", $time);
      end else begin
        exp_st = expected_states.pop_front();
        for (int i = 0; i < 10; i++)
          if (got[i] !== exp_st.f[i]) begin
            errors++;
            $display("%0t: %s expected %0d actual %0d", $time, names[i], exp_st.f[i], got[i]);
          end
      end
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic write_gain(logic [0:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_ACCEL_GAIN) model_accel_gain = longint'(val[23:0]);
    else model_yaw_gain = longint'(val[23:0]);
  endtask

  task automatic add_tick(int ms, int hd, int t0, int t1, int t2, int t3);
    tick_t t;
    t.step_ms = 10'(ms);
    t.heading = 16'(hd);
    t.trq = '{16'(t0), 16'(t1), 16'(t2), 16'(t3)};
    pending_ticks.push_back(t);
  endtask

  task automatic add_random_ticks(int n);
    tick_t t;
    for (int k = 0; k < n; k++) begin
      t.step_ms = ($urandom_range(9) == 0) ? 10'($urandom_range(1023)) :
                                             10'($urandom_range(1000));
      t.heading = ($urandom_range(7) == 0) ? 16'($urandom) :
                                             16'($urandom_range(51472) - 25736);
      for (int j = 0; j < 4; j++)
        t.trq[j] = ($urandom_range(3) == 0) ? 16'($urandom) :
                                              16'($urandom_range(2000) - 1000);
      pending_ticks.push_back(t);
    end
  endtask

  task automatic drain();
    wait (pending_ticks.size() == 0 && !in_valid && expected_states.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    for (int i = 0; i < 6; i++) model_rates[i] = 0;
    for (int i = 0; i < 4; i++) model_sums[i] = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    write_gain(REG_ACCEL_GAIN, 32'hFF01_0000);
    write_gain(REG_YAW_GAIN, 32'h0001_0000);
    // directed
    add_tick(0, 0, 0, 0, 0, 0);
    add_tick(1000, 0, 32767, 32767, 32767, 32767);
    add_tick(1000, 25736, -32768, -32768, -32768, -32768);
    add_tick(1000, -25736, 32767, -32768, 32767, -32768);
    add_tick(1023, 12868, 256, -256, -256, 256);
    add_tick(1023, -12868, -32768, 32767, 32767, -32768);
    add_tick(0, 20000, 1000, 2000, 3000, 4000);
    add_tick(0, -20000, -1000, 0, 1000, 0);
    add_tick(500, 32767, 5000, 5000, 0, 0);
    add_tick(500, -32768, 0, 0, 5000, 5000);
    add_tick(1, 13000, 100, 0, 0, 0);
    add_tick(1, -13000, 0, 100, 0, 0);
    add_tick(1000, 12900, 0, 0, 100, 0);
    add_tick(1000, -12900, 0, 0, 0, 100);
    add_tick(1023, 0, 0, 0, 0, 0);
    add_tick(1000, 16384, -1, -1, -1, -1);
    add_tick(1000, 0, 32767, 32767, 32767, 32767);
    add_tick(1000, 0, 32767, 32767, 32767, 32767);
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_gain(REG_ACCEL_GAIN, $urandom_range(262143));
          write_gain(REG_YAW_GAIN, $urandom);
        end
        1: begin
          write_gain(REG_ACCEL_GAIN, 32'hFFFF_FFFF);
          write_gain(REG_YAW_GAIN, 32'h00FF_FFFF);
        end
        2: begin
          write_gain(REG_ACCEL_GAIN, 32'h0);
          write_gain(REG_YAW_GAIN, 32'hAA00_0000);
        end
        default: begin
          write_gain(REG_ACCEL_GAIN, $urandom);
          write_gain(REG_YAW_GAIN, $urandom_range(131072));
        end
      endcase
      tx_idle_pct = (ph == 0) ? 34 : (ph == 1) ? 73 : 0;
      rx_idle_pct = (ph == 0) ? 73 : (ph == 1) ? 34 : 0;
      add_random_ticks(408);
      drain();
    end
    repeat (400) @(posedge clk);
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule
